// File: rtl/core/hpm_pkg.sv
`timescale 1ns / 1ps

package hpm_pkg;

	// coordinate and coefficient word
	localparam int COORD_W = 32;
	// weighted sum, two products plus offset, two's complement
	localparam int ZW = 66;
	// magnitude of a weighted sum
	localparam int MAG_W = 64;
	// doubled denominator magnitude
	localparam int DEN_W = 65;
	// partial remainder held between division cells
	localparam int REM_W = 65;
	// quotient bits produced by the cell chain (one per cell)
	localparam int QBITS = 33;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0001_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_RST = 64'h0;
	localparam logic [CFG_DATA_W-1:0] TRANS_RST = 64'h0;
	localparam logic [COORD_W-1:0] OFFSET_RST = 32'h0001_0000;

	localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_TRANS,
		REG_OFFSET
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] src_x;
		logic signed [COORD_W-1:0] src_y;
	} src_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] dst_x;
		logic signed [COORD_W-1:0] dst_y;
		logic invalid;
	} dst_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] m0;
		logic signed [COORD_W-1:0] m1;
		logic signed [COORD_W-1:0] m2;
		logic signed [COORD_W-1:0] m3;
		logic signed [COORD_W-1:0] m4;
		logic signed [COORD_W-1:0] m5;
		logic signed [COORD_W-1:0] m6;
		logic signed [COORD_W-1:0] m7;
		logic signed [COORD_W-1:0] m8;
	} coef_t;

	// one request in flight through the divider chain, both lanes
	// qn: remaining dividend bits shift out at the top, quotient bits in at the bottom
	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [REM_W-1:0] rem0;
		logic [REM_W-1:0] rem1;
		logic [QBITS-1:0] qn0;
		logic [QBITS-1:0] qn1;
		logic ovf0;
		logic ovf1;
		logic neg0;
		logic neg1;
		logic nneg0;
		logic nneg1;
		logic nz0;
		logic nz1;
		logic zden;
	} div_work_t;

endpackage

// File: rtl/core/hpm_stream_if.sv
`timescale 1ns / 1ps

interface hpm_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/hpm_front.sv
`timescale 1ns / 1ps

// products, sums, magnitudes, dividend build and range check
module hpm_front #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input hpm_pkg::src_item_t in_item,
	input hpm_pkg::coef_t coef,
	output logic out_valid,
	output hpm_pkg::div_work_t out_work
);

	localparam int NUM_W = hpm_pkg::ZW + FRAC_BITS;
	localparam int HI_W = NUM_W - hpm_pkg::QBITS;

	logic signed [2*hpm_pkg::COORD_W-1:0] prod_s1 [6];
	logic [hpm_pkg::ZW-1:0] z_s2 [3];
	logic [hpm_pkg::MAG_W-1:0] nm0_s3, nm1_s3, dm_s3;
	logic nneg0_s3, nneg1_s3, dneg_s3;
	logic [NUM_W-1:0] num0_s4, num1_s4;
	logic [hpm_pkg::DEN_W-1:0] den_s4;
	logic neg0_s4, neg1_s4, nneg0_s4, nneg1_s4, nz0_s4, nz1_s4, zden_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	hpm_pkg::div_work_t work_s5;

	logic [hpm_pkg::ZW-1:0] sum_c [3];
	logic [hpm_pkg::ZW-1:0] off_c [3];
	logic [hpm_pkg::ZW-1:0] mag_c [3];
	logic [NUM_W-1:0] num0_c, num1_c;
	logic [HI_W-1:0] hi0_c, hi1_c;
	logic ovf0_c, ovf1_c;

	function automatic logic [hpm_pkg::ZW-1:0] sext_p(input logic [2*hpm_pkg::COORD_W-1:0] p);
		return {{(hpm_pkg::ZW - 2*hpm_pkg::COORD_W){p[2*hpm_pkg::COORD_W-1]}}, p};
	endfunction

	function automatic logic [hpm_pkg::ZW-1:0] off_term(input logic [hpm_pkg::COORD_W-1:0] o);
		return {{(hpm_pkg::ZW - hpm_pkg::COORD_W - FRAC_BITS){o[hpm_pkg::COORD_W-1]}}, o,
			{FRAC_BITS{1'b0}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// s1: six signed products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= coef.m0 * in_item.src_x;
			prod_s1[1] <= coef.m1 * in_item.src_y;
			prod_s1[2] <= coef.m3 * in_item.src_x;
			prod_s1[3] <= coef.m4 * in_item.src_y;
			prod_s1[4] <= coef.m6 * in_item.src_x;
			prod_s1[5] <= coef.m7 * in_item.src_y;
		end
	end

	// s2: weighted sums, offsets aligned to the product scale
	always_comb begin
		off_c[0] = off_term(coef.m2);
		off_c[1] = off_term(coef.m5);
		off_c[2] = off_term(coef.m8);
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = sext_p(prod_s1[2*i]) + sext_p(prod_s1[2*i+1]) + off_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= sum_c;
		end
	end

	// s3: sign and magnitude; magnitudes always fit 64 bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = z_s2[i][hpm_pkg::ZW-1] ? (hpm_pkg::ZW'(0) - z_s2[i]) : z_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm0_s3 <= mag_c[0][hpm_pkg::MAG_W-1:0];
			nm1_s3 <= mag_c[1][hpm_pkg::MAG_W-1:0];
			dm_s3 <= mag_c[2][hpm_pkg::MAG_W-1:0];
			nneg0_s3 <= z_s2[0][hpm_pkg::ZW-1];
			nneg1_s3 <= z_s2[1][hpm_pkg::ZW-1];
			dneg_s3 <= z_s2[2][hpm_pkg::ZW-1];
		end
	end

	// s4: dividend = 2*n*2^F + d over 2*d gives the half-up rounded quotient
	always_comb begin
		num0_c = {1'b0, nm0_s3, {(FRAC_BITS+1){1'b0}}} + {{(FRAC_BITS+2){1'b0}}, dm_s3};
		num1_c = {1'b0, nm1_s3, {(FRAC_BITS+1){1'b0}}} + {{(FRAC_BITS+2){1'b0}}, dm_s3};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s4 <= num0_c;
			num1_s4 <= num1_c;
			den_s4 <= {dm_s3, 1'b0};
			neg0_s4 <= nneg0_s3 ^ dneg_s3;
			neg1_s4 <= nneg1_s3 ^ dneg_s3;
			nneg0_s4 <= nneg0_s3;
			nneg1_s4 <= nneg1_s3;
			nz0_s4 <= |nm0_s3;
			nz1_s4 <= |nm1_s3;
			zden_s4 <= ~|dm_s3;
		end
	end

	// s5: quotient needs more than QBITS bits when the top part already reaches den
	always_comb begin
		hi0_c = num0_s4[NUM_W-1:hpm_pkg::QBITS];
		hi1_c = num1_s4[NUM_W-1:hpm_pkg::QBITS];
		ovf0_c = {{hpm_pkg::QBITS{1'b0}}, hi0_c} >= {{(NUM_W-hpm_pkg::DEN_W){1'b0}}, den_s4};
		ovf1_c = {{hpm_pkg::QBITS{1'b0}}, hi1_c} >= {{(NUM_W-hpm_pkg::DEN_W){1'b0}}, den_s4};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s5.den <= den_s4;
			work_s5.rem0 <= {{(hpm_pkg::REM_W-HI_W){1'b0}}, hi0_c};
			work_s5.rem1 <= {{(hpm_pkg::REM_W-HI_W){1'b0}}, hi1_c};
			work_s5.qn0 <= num0_s4[hpm_pkg::QBITS-1:0];
			work_s5.qn1 <= num1_s4[hpm_pkg::QBITS-1:0];
			work_s5.ovf0 <= ovf0_c;
			work_s5.ovf1 <= ovf1_c;
			work_s5.neg0 <= neg0_s4;
			work_s5.neg1 <= neg1_s4;
			work_s5.nneg0 <= nneg0_s4;
			work_s5.nneg1 <= nneg1_s4;
			work_s5.nz0 <= nz0_s4;
			work_s5.nz1 <= nz1_s4;
			work_s5.zden <= zden_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_work = work_s5;

endmodule

// File: rtl/core/hpm_div_cell.sv
`timescale 1ns / 1ps

// one restoring division step for both lanes
module hpm_div_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input hpm_pkg::div_work_t in_work,
	output logic out_valid,
	output hpm_pkg::div_work_t out_work
);

	typedef struct packed {
		logic [hpm_pkg::REM_W-1:0] rem;
		logic [hpm_pkg::QBITS-1:0] qn;
	} step_t;

	hpm_pkg::div_work_t work_q;
	hpm_pkg::div_work_t nxt_c;
	step_t lane0_c, lane1_c;
	logic valid_q;

	function automatic step_t div_step(
		input logic [hpm_pkg::REM_W-1:0] rem,
		input logic [hpm_pkg::QBITS-1:0] qn,
		input logic [hpm_pkg::DEN_W-1:0] den
	);
		logic [hpm_pkg::REM_W:0] trial;
		logic [hpm_pkg::REM_W+1:0] diff;
		logic ge;
		step_t r;
		trial = {rem, qn[hpm_pkg::QBITS-1]};
		diff = {1'b0, trial} - {2'b00, den};
		ge = ~diff[hpm_pkg::REM_W+1];
		r.rem = ge ? diff[hpm_pkg::REM_W-1:0] : trial[hpm_pkg::REM_W-1:0];
		r.qn = {qn[hpm_pkg::QBITS-2:0], ge};
		return r;
	endfunction

	always_comb begin
		lane0_c = div_step(in_work.rem0, in_work.qn0, in_work.den);
		lane1_c = div_step(in_work.rem1, in_work.qn1, in_work.den);
		nxt_c = in_work;
		nxt_c.rem0 = lane0_c.rem;
		nxt_c.qn0 = lane0_c.qn;
		nxt_c.rem1 = lane1_c.rem;
		nxt_c.qn1 = lane1_c.qn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= nxt_c;
		end
	end

	assign out_valid = valid_q;
	assign out_work = work_q;

endmodule

// File: rtl/core/homography_point_map.sv
`timescale 1ns / 1ps

// Projective point mapper: (x, y) -> ((m0 x + m1 y + m2) / (m6 x + m7 y + m8),
// (m3 x + m4 y + m5) / (m6 x + m7 y + m8)), signed fixed point, FRAC_BITS fraction bits.
// src: request carries src_x, src_y; taken when valid and ready are high at a clock edge.
// dst: request carries dst_x, dst_y and invalid (zero denominator or saturated quotient).
// cfg: write port, cfg_index selects the coefficient register, taken when cfg_we is high;
//   rewrite registers only while no request is in flight; the block does not enforce it.
// From acceptance to dst.valid a request passes 5 front stages (multiply, sum,
// magnitude, dividend build, range check), 33 division cells (one quotient bit each,
// both coordinates side by side sharing the denominator), one output register.
// Throughput is one request per cycle; cells advance every cycle the skid is empty.
// Reset loads the identity mapping and empties the pipeline.
// When dst stalls, the held result sits in the output register and the next one lands
// in a skid register; src.ready drops only while the skid register is full, and then
// the whole pipeline holds in place until dst takes a request.
module homography_point_map #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	hpm_stream_if.sink src,
	hpm_stream_if.source dst,
	input logic cfg_we,
	input logic [hpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hpm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NCELLS = hpm_pkg::QBITS;

	typedef struct packed {
		logic bad;
		logic [hpm_pkg::COORD_W-1:0] value;
	} lane_res_t;

	// coefficient registers
	logic [hpm_pkg::CFG_DATA_W-1:0] row0_q, row1_q, row2_q, trans_q;
	logic [hpm_pkg::COORD_W-1:0] offset_q;
	hpm_pkg::coef_t coef;

	// pipeline control
	logic en;
	logic accept;

	logic chain_valid [NCELLS+1];
	hpm_pkg::div_work_t chain_work [NCELLS+1];

	// output side
	hpm_pkg::dst_item_t res_c;
	lane_res_t lane0_c, lane1_c;
	hpm_pkg::dst_item_t out_q, skid_q;
	logic out_v_q, skid_v_q;

	// rounded quotient magnitude to signed result, with clamping
	function automatic lane_res_t finish_lane(
		input logic [hpm_pkg::QBITS-1:0] q,
		input logic ovf,
		input logic neg,
		input logic nz,
		input logic nneg,
		input logic zden
	);
		lane_res_t r;
		logic [hpm_pkg::QBITS-1:0] qneg;
		qneg = hpm_pkg::QBITS'(0) - q;
		if (zden) begin
			r.bad = 1'b1;
			if (!nz) begin
				r.value = '0;
			end else begin
				r.value = nneg ? hpm_pkg::SAT_NEG : hpm_pkg::SAT_POS;
			end
		end else if (!neg) begin
			r.bad = ovf | q[hpm_pkg::QBITS-1] | q[hpm_pkg::QBITS-2];
			r.value = r.bad ? hpm_pkg::SAT_POS : q[hpm_pkg::COORD_W-1:0];
		end else begin
			// magnitude up to 2^31 is representable when negative
			r.bad = ovf | (q > {1'b0, hpm_pkg::SAT_NEG});
			r.value = r.bad ? hpm_pkg::SAT_NEG : qneg[hpm_pkg::COORD_W-1:0];
		end
		return r;
	endfunction

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= hpm_pkg::ROW0_RST;
			row1_q <= hpm_pkg::ROW1_RST;
			row2_q <= hpm_pkg::ROW2_RST;
			trans_q <= hpm_pkg::TRANS_RST;
			offset_q <= hpm_pkg::OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpm_pkg::REG_ROW0: row0_q <= cfg_data;
				hpm_pkg::REG_ROW1: row1_q <= cfg_data;
				hpm_pkg::REG_ROW2: row2_q <= cfg_data;
				hpm_pkg::REG_TRANS: trans_q <= cfg_data;
				hpm_pkg::REG_OFFSET: offset_q <= cfg_data[hpm_pkg::COORD_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// upper half of each pair is the first coefficient
	always_comb begin
		coef.m0 = row0_q[63:32];
		coef.m1 = row0_q[31:0];
		coef.m3 = row1_q[63:32];
		coef.m4 = row1_q[31:0];
		coef.m6 = row2_q[63:32];
		coef.m7 = row2_q[31:0];
		coef.m2 = trans_q[63:32];
		coef.m5 = trans_q[31:0];
		coef.m8 = offset_q;
	end

	// ---- pipeline ----
	// everything advances together unless the skid register holds a result
	assign en = ~skid_v_q;
	assign src.ready = en;
	assign accept = src.valid & en;

	hpm_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(accept),
		.in_item(src.data),
		.coef(coef),
		.out_valid(chain_valid[0]),
		.out_work(chain_work[0])
	);

	// one quotient bit per cell, most significant first
	for (genvar g = 0; g < NCELLS; g++) begin : g_cell
		hpm_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(chain_valid[g]),
			.in_work(chain_work[g]),
			.out_valid(chain_valid[g+1]),
			.out_work(chain_work[g+1])
		);
	end

	// ---- result formatting ----
	always_comb begin
		lane0_c = finish_lane(chain_work[NCELLS].qn0, chain_work[NCELLS].ovf0,
			chain_work[NCELLS].neg0, chain_work[NCELLS].nz0,
			chain_work[NCELLS].nneg0, chain_work[NCELLS].zden);
		lane1_c = finish_lane(chain_work[NCELLS].qn1, chain_work[NCELLS].ovf1,
			chain_work[NCELLS].neg1, chain_work[NCELLS].nz1,
			chain_work[NCELLS].nneg1, chain_work[NCELLS].zden);
		res_c.dst_x = lane0_c.value;
		res_c.dst_y = lane1_c.value;
		res_c.invalid = lane0_c.bad | lane1_c.bad;
	end

	// ---- output register and skid ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || dst.ready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= en & chain_valid[NCELLS];
			end
		end else if (en && chain_valid[NCELLS]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || dst.ready) begin
			out_q <= skid_v_q ? skid_q : res_c;
		end else if (en && chain_valid[NCELLS]) begin
			skid_q <= res_c;
		end
	end

	assign dst.valid = out_v_q;
	assign dst.data = out_q;

endmodule
